[design/pu_pkg.sv]
// Shared types, constants, factorial table and microcode for the permutation unranker.
`default_nettype none

package pu_pkg;

  localparam int SYMBOLS_DEF = 10;  // default length of the symbol list
  localparam int RANK_W      = 22;
  localparam int CNT_W       = 4;   // digit_count, position and step counter
  localparam int DIGIT_W     = 4;
  localparam int FACT_W      = 29;  // holds 12!
  localparam int SH_W        = 2;   // quotient bit selector
  localparam int Q_W         = 1 << SH_W;
  localparam int DIV_W       = FACT_W + Q_W - 1;
  localparam int UPC_W       = 4;

  // Microcode addresses that are jump targets
  localparam logic [UPC_W-1:0] A_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] A_DIV  = 4'd2;
  localparam logic [UPC_W-1:0] A_ERR  = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_ERR,
    C_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic [SH_W-1:0]  sh;
  } uword_t;

  typedef struct packed {
    op_e             op;
    logic            go;
    logic [SH_W-1:0] sh;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic err;
    logic more;
  } stat_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  digit_count;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CNT_W-1:0]   position;
    logic               last;
    logic               error;
  } out_t;

  function automatic logic [FACT_W-1:0] fact_f(input logic [CNT_W-1:0] n);
    logic [FACT_W-1:0] f;
    unique case (n)
      4'd0:    f = FACT_W'(1);
      4'd1:    f = FACT_W'(1);
      4'd2:    f = FACT_W'(2);
      4'd3:    f = FACT_W'(6);
      4'd4:    f = FACT_W'(24);
      4'd5:    f = FACT_W'(120);
      4'd6:    f = FACT_W'(720);
      4'd7:    f = FACT_W'(5040);
      4'd8:    f = FACT_W'(40320);
      4'd9:    f = FACT_W'(362880);
      4'd10:   f = FACT_W'(3628800);
      4'd11:   f = FACT_W'(39916800);
      4'd12:   f = FACT_W'(479001600);
      default: f = '1;
    endcase
    return f;
  endfunction

  // Control store: load, error check, four restoring-divide steps, emit, loop
  function automatic uword_t ucode_f(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      4'd0:    w = '{OP_LOAD, C_NEXT,   A_IDLE, SH_W'(0)};
      4'd1:    w = '{OP_NOP,  C_ERR,    A_ERR,  SH_W'(0)};
      4'd2:    w = '{OP_DIV,  C_NEXT,   A_IDLE, SH_W'(3)};
      4'd3:    w = '{OP_DIV,  C_NEXT,   A_IDLE, SH_W'(2)};
      4'd4:    w = '{OP_DIV,  C_NEXT,   A_IDLE, SH_W'(1)};
      4'd5:    w = '{OP_DIV,  C_NEXT,   A_IDLE, SH_W'(0)};
      4'd6:    w = '{OP_EMIT, C_MORE,   A_DIV,  SH_W'(0)};
      4'd7:    w = '{OP_NOP,  C_ALWAYS, A_IDLE, SH_W'(0)};
      4'd8:    w = '{OP_ERR,  C_ALWAYS, A_IDLE, SH_W'(0)};
      default: w = '{OP_NOP,  C_ALWAYS, A_IDLE, SH_W'(0)};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/permutation_unrank.sv]
// The first result is registered by the emit step that follows the error check and divide steps.
// A new item is taken only once the previous one is done, and an error item skips the digits;
// each digit costs four shift-subtract steps on the shared divider plus one emit step.
// Results sit in an output register; an emit step stalls only when it is still full.
// Reset (asynchronous, active low) clears the step counter and the result valid flag.
`default_nettype none

module permutation_unrank
  import pu_pkg::*;
#(
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  pu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pu_dp #(
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // the error result is a lone, final, all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |->
      (out_data_o.last && out_data_o.digit == '0 && out_data_o.position == '0))
    else $error("malformed error result");

  // a chosen digit always comes from the symbol list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.error) |->
      (out_data_o.digit < DIGIT_W'(SYMBOLS) && out_data_o.position < CNT_W'(SYMBOLS)))
    else $error("digit or position outside the symbol list");

  // a new item is only taken once the previous one has left its last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last && in_ready_o) |-> 1'b0)
    else $error("input opened before the last result of the item");
`endif

endmodule

`default_nettype wire

[design/pu_seq.sv]
// Microcode sequencer: step counter, control store and next-address logic.
`default_nettype none

module pu_seq
  import pu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             go;
  logic             taken;

  always_comb begin
    uw = ucode_f(upc_q);

    // handshake steps hold until their transfer can happen
    unique case (uw.op) inside
      OP_LOAD:         go = stat_i.in_valid;
      OP_EMIT, OP_ERR: go = stat_i.out_free;
      default:         go = 1'b1;
    endcase

    unique case (uw.cond)
      C_NEXT:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_ERR:    taken = stat_i.err;
      C_MORE:   taken = stat_i.more;
      default:  taken = 1'b0;
    endcase

    if (!go) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end

    ctrl_o.op = uw.op;
    ctrl_o.go = go;
    ctrl_o.sh = uw.sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[design/pu_dp.sv]
// Datapath: rank, step and position counters, shift-subtract divider, symbol list, result register.
`default_nettype none

module pu_dp
  import pu_pkg::*;
#(
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  output stat_t      stat_o,
  input  wire logic  in_valid_i,
  input  wire in_t   in_data_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output out_t       out_data_o
);

  localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [CNT_W-1:0]   s_q, s_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [Q_W-1:0]     q_q, q_d;
  logic               err_q, err_d;
  logic [DIGIT_W-1:0] list_q [SYMBOLS];
  logic [DIGIT_W-1:0] list_d [SYMBOLS];
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic [DIV_W-1:0]   trial;
  logic               take;
  logic [IDX_W-1:0]   idx;
  logic               err_in;
  logic               out_free;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    trial    = DIV_W'(fact_f(s_q - CNT_W'(1))) << ctrl_i.sh;
    take     = DIV_W'(rank_q) >= trial;
    idx      = q_q[IDX_W-1:0];
    err_in   = (in_data_i.digit_count == '0) ||
               (in_data_i.digit_count > CNT_W'(SYMBOLS)) ||
               (FACT_W'(in_data_i.rank) >= fact_f(in_data_i.digit_count));

    rank_d      = rank_q;
    s_d         = s_q;
    n_d         = n_q;
    q_d         = q_q;
    err_d       = err_q;
    list_d      = list_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (ctrl_i.go) begin
      case (ctrl_i.op)
        OP_LOAD: begin
          rank_d = in_data_i.rank;
          s_d    = in_data_i.digit_count;
          n_d    = '0;
          q_d    = '0;
          err_d  = err_in;
          for (int i = 0; i < SYMBOLS; i++) begin
            list_d[i] = DIGIT_W'(i);
          end
        end
        OP_DIV: begin
          if (take) begin
            rank_d          = rank_q - trial[RANK_W-1:0];
            q_d[ctrl_i.sh]  = 1'b1;
          end
        end
        OP_EMIT: begin
          out_valid_d    = 1'b1;
          out_d.digit    = list_q[idx];
          out_d.position = n_q;
          out_d.last     = (s_q == CNT_W'(1));
          out_d.error    = 1'b0;
          // close the gap left by the chosen entry
          for (int i = 0; i < SYMBOLS - 1; i++) begin
            if (IDX_W'(i) >= idx) begin
              list_d[i] = list_q[i+1];
            end
          end
          s_d = s_q - CNT_W'(1);
          n_d = n_q + CNT_W'(1);
          q_d = '0;
        end
        OP_ERR: begin
          out_valid_d    = 1'b1;
          out_d.digit    = '0;
          out_d.position = '0;
          out_d.last     = 1'b1;
          out_d.error    = 1'b1;
        end
        default: begin
        end
      endcase
    end

    stat_o.in_valid = in_valid_i;
    stat_o.out_free = out_free;
    stat_o.err      = err_q;
    stat_o.more     = (s_q != CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    s_q    <= s_d;
    n_q    <= n_d;
    q_q    <= q_d;
    err_q  <= err_d;
    list_q <= list_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (ctrl_i.op == OP_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[tb/sv/permutation_unrank_checker.sv]
// Checker for the permutation unranker: predicts the digit stream and compares transfers.
module permutation_unrank_checker
  import pu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   pending_o,
  output int   mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t digits_exp_q[$];
  int   mismatch_cnt = 0;

  assign pending_o    = digits_exp_q.size();
  assign mismatches_o = mismatch_cnt;

  function automatic longint unsigned factorial(input int unsigned n);
    longint unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= n; i++) f *= i;
    return f;
  endfunction

  // Expands one request into its digit results; pool holds the unused symbols in order.
  function automatic void unrank_digits(input in_t item);
    logic [DIGIT_W-1:0] pool[SYMBOLS_DEF];
    longint unsigned    rem, f, quo;
    int unsigned        k, len, idx;
    out_t               res;
    k   = item.digit_count;
    rem = item.rank;
    if (k == 0 || k > SYMBOLS_DEF || rem >= factorial(k)) begin
      res = '{digit: '0, position: '0, last: 1'b1, error: 1'b1};
      digits_exp_q.push_back(res);
      return;
    end
    for (int i = 0; i < SYMBOLS_DEF; i++) pool[i] = DIGIT_W'(i);
    len = SYMBOLS_DEF;
    for (int s = k; s >= 1; s--) begin
      f   = factorial(s - 1);
      quo = rem / f;
      idx = (quo < len) ? int'(quo) : len - 1;
      res.digit    = pool[idx];
      res.position = CNT_W'(k - s);
      res.last     = (s == 1);
      res.error    = 1'b0;
      for (int unsigned i = idx; i + 1 < len; i++) pool[i] = pool[i+1];
      len--;
      rem = rem % f;
      digits_exp_q.push_back(res);
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) unrank_digits(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (digits_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result digit=%0d pos=%0d last=%0b err=%0b", $realtime,
                     out_data_i.digit, out_data_i.position, out_data_i.last,
                     out_data_i.error);
        end else begin
          want = digits_exp_q.pop_front();
          if (want.digit !== out_data_i.digit || want.position !== out_data_i.position ||
              want.last !== out_data_i.last || want.error !== out_data_i.error) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch exp digit=%0d pos=%0d last=%0b err=%0b, got %0d %0d %0b %0b",
                       $realtime, want.digit, want.position, want.last, want.error,
                       out_data_i.digit, out_data_i.position, out_data_i.last,
                       out_data_i.error);
          end
        end
      end
    end
  end

endmodule

[tb/sv/permutation_unrank_test.sv]
// Testbench top for the permutation unranker: clock, reset, stimulus and verdict.
module permutation_unrank_test;
  import pu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   pending;
  int   mismatches;
  bit   no_idle   = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  permutation_unrank i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  permutation_unrank_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  function automatic int unsigned perm_count(input int unsigned k);
    int unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= k; i++) f *= i;
    return f;
  endfunction

  // Valid stays high across back-to-back transfers when the drawn gap is zero.
  task automatic send_item(input logic [RANK_W-1:0] r, input logic [CNT_W-1:0] k);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid            <= 1'b1;
    in_data.rank        <= r;
    in_data.digit_count <= k;
    do @(posedge clk_i); while (!(in_valid && in_ready));
  endtask

  // Result side: random stall before each transfer
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int unsigned sel, k, lo;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, exact-factorial boundaries, illegal counts
    send_item(0, 1);
    send_item(1, 1);
    send_item(0, 10);
    send_item(3628799, 10);
    send_item(3628800, 10);
    send_item(22'h3FFFFF, 10);
    send_item(0, 0);
    send_item(5, 0);
    send_item(0, 11);
    send_item(100, 12);
    send_item(22'h3FFFFF, 15);
    send_item(1, 2);
    send_item(2, 2);
    send_item(5, 3);
    send_item(6, 3);
    send_item(23, 4);
    send_item(119, 5);
    send_item(719, 6);
    send_item(5039, 7);
    send_item(40319, 8);
    send_item(362879, 9);
    send_item(362880, 9);
    send_item(1234567, 10);
    send_item(2097152, 10);

    for (int n = 0; n < 200; n++) begin
      no_idle = ((n / 40) % 3) == 1;
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        k = $urandom_range(1, 10);
        send_item(RANK_W'($urandom_range(0, perm_count(k) - 1)), CNT_W'(k));
      end else if (sel < 93) begin
        k  = $urandom_range(1, 10);
        lo = perm_count(k);
        send_item(RANK_W'($urandom_range(lo, 32'h3FFFFF)), CNT_W'(k));
      end else begin
        // count out of range: zero or above the symbol list
        k = $urandom_range(10, 15);
        if (k == 10) k = 0;
        send_item(RANK_W'($urandom_range(0, 32'h3FFFFF)), CNT_W'(k));
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
